// ===== rtl/core/tun_pkg.sv =====
package tun_pkg;

   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
   localparam logic [31:0] HALF_BITS  = 32'h3F00_0000;
   localparam logic [31:0] THREE_HALF = 32'h3FC0_0000;
   localparam logic [31:0] RSQRT_SEED = 32'h5F37_59DF;

   typedef struct packed {
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } vec3_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } flow_type;

   // Rounds a 27-bit significand (hidden bit on top, guard/round/sticky below)
   // to nearest even and packs it; exponent is biased and may be out of range.
   function automatic logic [31:0] fp_pack(logic s, logic signed [10:0] e, logic [26:0] m);
      logic signed [10:0] diff;
      logic [4:0]         amt;
      logic [26:0]        sh;
      logic               lost;
      logic               up;
      logic [30:0]        res;
      logic [26:0]        mm;
      logic [7:0]         ee;
      mm = m;
      ee = e[7:0];
      if (e >= 11'sd255) begin
         return {s, 8'hFF, 23'b0};
      end
      if (e <= 11'sd0) begin
         diff = 11'sd1 - e;
         amt  = (diff > 11'sd27) ? 5'd27 : diff[4:0];
         sh   = m >> amt;
         lost = |(m & ((27'h1 << amt) - 27'h1));
         mm   = {sh[26:1], sh[0] | lost};
         ee   = 8'd0;
      end
      up  = mm[2] & (mm[1] | mm[0] | mm[3]);
      res = {ee, mm[25:3]} + {30'b0, up};
      return {s, res};
   endfunction

   function automatic logic [31:0] fp_canon(logic [31:0] a);
      if (a[30:23] == 8'hFF && a[22:0] != 23'b0) begin
         return QNAN_BITS;
      end
      return a;
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic               s;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        p;
      logic [47:0]        pn;
      logic [5:0]         k;
      logic signed [10:0] e;
      logic               anan, bnan, ainf, binf, azero, bzero;
      s     = a[31] ^ b[31];
      anan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
      bnan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
      ainf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
      binf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
      azero = (a[30:0] == 31'b0);
      bzero = (b[30:0] == 31'b0);
      if (anan || bnan || (ainf && bzero) || (binf && azero)) begin
         return QNAN_BITS;
      end
      if (ainf || binf) begin
         return {s, 8'hFF, 23'b0};
      end
      if (azero || bzero) begin
         return {s, 31'b0};
      end
      ma = {|a[30:23], a[22:0]};
      mb = {|b[30:23], b[22:0]};
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      p  = ma * mb;
      k  = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (p[i]) begin
            k = 6'(i);
         end
      end
      pn = p << (6'd47 - k);
      e  = $signed(11'(ea) + 11'(eb) + 11'(k)) - 11'sd173;
      return fp_pack(s, e, {pn[47:22], |pn[21:0]});
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [31:0]        x;
      logic [31:0]        y;
      logic [7:0]         ex;
      logic [7:0]         ey;
      logic [7:0]         diff;
      logic [5:0]         amt;
      logic [49:0]        ax;
      logic [49:0]        bfull;
      logic [49:0]        bsh;
      logic [50:0]        sum;
      logic [50:0]        sn;
      logic [5:0]         k;
      logic signed [10:0] e;
      logic               anan, bnan, ainf, binf;
      anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
      bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
      ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
      binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
      if (anan || bnan || (ainf && binf && (a[31] != b[31]))) begin
         return QNAN_BITS;
      end
      if (ainf) begin
         return a;
      end
      if (binf) begin
         return b;
      end
      if (a[30:0] < b[30:0]) begin
         x = b;
         y = a;
      end else begin
         x = a;
         y = b;
      end
      ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      diff  = ex - ey;
      amt   = (diff > 8'd50) ? 6'd50 : diff[5:0];
      ax    = {|x[30:23], x[22:0], 26'b0};
      bfull = {|y[30:23], y[22:0], 26'b0};
      bsh   = bfull >> amt;
      bsh[0] = bsh[0] | (|(bfull & ((50'h1 << amt) - 50'h1)));
      if (x[31] == y[31]) begin
         sum = {1'b0, ax} + {1'b0, bsh};
      end else begin
         sum = {1'b0, ax} - {1'b0, bsh};
      end
      if (sum == 51'b0) begin
         return {x[31] & y[31], 31'b0};
      end
      k = 6'd0;
      for (int i = 0; i < 51; i++) begin
         if (sum[i]) begin
            k = 6'(i);
         end
      end
      sn = sum << (6'd50 - k);
      e  = $signed(11'(ex) + 11'(k)) - 11'sd49;
      return fp_pack(x[31], e, {sn[50:25], |sn[24:0]});
   endfunction

   function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
      return fp_add(a, {~b[31], b[30:0]});
   endfunction

endpackage

// ===== rtl/core/tun_cross.sv =====
module tun_cross
   import tun_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  flow_type flow_in,
   input  vec3_type first,
   input  vec3_type second,
   input  vec3_type third,
   output logic     valid_out,
   output vec3_type normal
);

   logic     v1_ff, v2_ff, v3_ff;
   vec3_type e_ff, f_ff, e_in, f_in;
   logic [31:0] p_ff [6];
   logic [31:0] p_in [6];
   vec3_type n_ff, n_in;

   always_comb begin
      e_in.x = fp_sub(second.x, first.x);
      e_in.y = fp_sub(second.y, first.y);
      e_in.z = fp_sub(second.z, first.z);
      f_in.x = fp_sub(third.x, first.x);
      f_in.y = fp_sub(third.y, first.y);
      f_in.z = fp_sub(third.z, first.z);
      p_in[0] = fp_mul(e_ff.y, f_ff.z);
      p_in[1] = fp_mul(e_ff.z, f_ff.y);
      p_in[2] = fp_mul(e_ff.z, f_ff.x);
      p_in[3] = fp_mul(e_ff.x, f_ff.z);
      p_in[4] = fp_mul(e_ff.x, f_ff.y);
      p_in[5] = fp_mul(e_ff.y, f_ff.x);
      n_in.x = fp_sub(p_ff[0], p_ff[1]);
      n_in.y = fp_sub(p_ff[2], p_ff[3]);
      n_in.z = fp_sub(p_ff[4], p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (flow_in.advance) begin
         v1_ff <= flow_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (flow_in.advance) begin
         e_ff <= e_in;
         f_ff <= f_in;
         p_ff <= p_in;
         n_ff <= n_in;
      end
   end

   assign valid_out = v3_ff;
   assign normal    = n_ff;

endmodule

// ===== rtl/core/tun_rsqrt.sv =====
module tun_rsqrt
   import tun_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  flow_type    flow_in,
   input  vec3_type    normal_in,
   output logic        valid_out,
   output vec3_type    normal_out,
   output logic [31:0] scale
);

   localparam int Depth = 8;

   logic     v_ff [Depth];
   vec3_type n_ff [Depth];
   vec3_type sq_ff, sq_in;
   logic [31:0] sq_z_ff, sxy_ff, sxy_in, d_ff, d_in;
   logic [31:0] y_ff [4];
   logic [31:0] y_in;
   logic [31:0] h_ff, h_in, t1_ff, t1_in, t_ff, t_in, s_ff, s_in, r_ff, r_in;

   always_comb begin
      sq_in.x = fp_mul(normal_in.x, normal_in.x);
      sq_in.y = fp_mul(normal_in.y, normal_in.y);
      sq_in.z = fp_mul(normal_in.z, normal_in.z);
      sxy_in  = fp_add(sq_ff.x, sq_ff.y);
      d_in    = fp_add(sxy_ff, sq_z_ff);
      y_in    = RSQRT_SEED - {1'b0, d_ff[31:1]};
      h_in    = fp_mul(d_ff, HALF_BITS);
      t1_in   = fp_mul(h_ff, y_ff[0]);
      t_in    = fp_mul(t1_ff, y_ff[1]);
      s_in    = fp_sub(THREE_HALF, t_ff);
      r_in    = fp_mul(y_ff[3], s_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (flow_in.advance) begin
         v_ff[0] <= flow_in.valid;
         for (int i = 1; i < Depth; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (flow_in.advance) begin
         n_ff[0] <= normal_in;
         for (int i = 1; i < Depth; i++) begin
            n_ff[i] <= n_ff[i-1];
         end
         sq_ff   <= sq_in;
         sxy_ff  <= sxy_in;
         sq_z_ff <= sq_ff.z;
         d_ff    <= d_in;
         y_ff[0] <= y_in;
         y_ff[1] <= y_ff[0];
         y_ff[2] <= y_ff[1];
         y_ff[3] <= y_ff[2];
         h_ff    <= h_in;
         t1_ff   <= t1_in;
         t_ff    <= t_in;
         s_ff    <= s_in;
         r_ff    <= r_in;
      end
   end

   assign valid_out  = v_ff[Depth-1];
   assign normal_out = n_ff[Depth-1];
   assign scale      = r_ff;

endmodule

// ===== rtl/core/triangle_unit_normal_top.sv =====
// Channel   Ports    Beat contents
// request   req_*    nine vertex words, one triangle
// response  rsp_*    raw normal and unit normal
// A triangle passes the cross-product, inverse-square-root and output stages, one
// single-precision operation per stage; a new triangle may enter each unstalled cycle.
// Reset clears only the stage valid bits.
// A stalled response halts every stage at once, so no beat is lost or repeated.
module triangle_unit_normal_top
   import tun_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, normal_z, unit_x, unit_y, unit_z
   output logic [191:0] rsp_tdata
);

   flow_type    flow;
   flow_type    rs_flow;
   logic        cross_valid, rs_valid;
   vec3_type    cross_n, rs_n;
   logic [31:0] scale;
   logic        out_valid_ff;
   logic [191:0] out_data_ff, out_data_in;

   assign flow.advance = !out_valid_ff || rsp_tready;
   assign flow.valid   = req_tvalid;
   assign req_tready   = flow.advance;

   assign rs_flow.advance = flow.advance;
   assign rs_flow.valid   = cross_valid;

   tun_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .flow_in   (flow),
      .first     (req_tdata[95:0]),
      .second    (req_tdata[191:96]),
      .third     (req_tdata[287:192]),
      .valid_out (cross_valid),
      .normal    (cross_n)
   );

   tun_rsqrt u_rsqrt (
      .clock      (clock),
      .reset      (reset),
      .flow_in    (rs_flow),
      .normal_in  (cross_n),
      .valid_out  (rs_valid),
      .normal_out (rs_n),
      .scale      (scale)
   );

   assign out_data_in = {fp_canon(fp_mul(rs_n.z, scale)),
                         fp_canon(fp_mul(rs_n.y, scale)),
                         fp_canon(fp_mul(rs_n.x, scale)),
                         fp_canon(rs_n.z),
                         fp_canon(rs_n.y),
                         fp_canon(rs_n.x)};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (flow.advance) begin
         out_valid_ff <= rs_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== test/triangle_unit_normal_top_tb.sv =====
`timescale 1ns / 1ps

module triangle_unit_normal_top_tb
   import tun_pkg::*;
();

   typedef struct {
      logic [31:0] nx, ny, nz, ux, uy, uz;
   } normal_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;

   normal_beat_type normals_due[$];
   int           mismatches = 0;
   bit           stall_free = 1'b0;

   triangle_unit_normal_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] round_single(logic s, logic [95:0] m, int e);
      int          p;
      int          bexp;
      int          shift;
      longint      q;
      longint      bits;
      logic        half;
      logic        sticky;
      logic [95:0] t;
      p = 0;
      for (int i = 0; i < 96; i++) begin
         if (m[i]) begin
            p = i;
         end
      end
      bexp  = p + e + 127;
      shift = (bexp >= 1) ? p - 23 : -149 - e;
      half   = 1'b0;
      sticky = 1'b0;
      if (shift <= 0) begin
         t = m << (-shift);
         q = longint'(t[40:0]);
      end else if (shift > 96) begin
         q      = 0;
         sticky = |m;
      end else begin
         t      = m >> shift;
         q      = longint'(t[40:0]);
         half   = m[shift-1];
         sticky = |(m & ((96'b1 << (shift - 1)) - 96'b1));
      end
      if (half && (sticky || q[0])) begin
         q = q + 1;
      end
      bits = (bexp >= 1) ? ((longint'(bexp - 1) << 23) + q) : q;
      if (bits >= 64'h7F80_0000) begin
         return {s, 8'hFF, 23'b0};
      end
      return {s, bits[30:0]};
   endfunction

   function automatic bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   function automatic bit is_inf(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 0;
   endfunction

   function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
      logic s;
      int   ea;
      int   eb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 0)
          || (is_inf(b) && a[30:0] == 0)) begin
         return QNAN_BITS;
      end
      if (is_inf(a) || is_inf(b)) begin
         return {s, 8'hFF, 23'b0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) begin
         return {s, 31'b0};
      end
      ea = ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
      eb = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
      return round_single(s, 96'({|a[30:23], a[22:0]}) * 96'({|b[30:23], b[22:0]}),
                          ea + eb);
   endfunction

   function automatic logic [31:0] single_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      int          xe;
      int          ye;
      int          diff;
      int          lead;
      int          rest;
      logic [95:0] mx;
      logic [95:0] my;
      logic [95:0] sum;
      logic        s;
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) begin
         return QNAN_BITS;
      end
      if (is_inf(a)) begin
         return a;
      end
      if (is_inf(b)) begin
         return b;
      end
      if (a[30:0] == 0 && b[30:0] == 0) begin
         return {a[31] & b[31], 31'b0};
      end
      if (a[30:23] >= b[30:23]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      xe   = (x[30:23] == 0) ? 1 : int'(x[30:23]);
      ye   = (y[30:23] == 0) ? 1 : int'(y[30:23]);
      diff = xe - ye;
      lead = (diff > 40) ? 40 : diff;
      rest = diff - lead;
      mx   = 96'({|x[30:23], x[22:0]}) << lead;
      my   = 96'({|y[30:23], y[22:0]});
      if (rest >= 24) begin
         my = {95'b0, |my};
      end else if (rest > 0) begin
         my = (my >> rest) | 96'(|(my & ((96'b1 << rest) - 96'b1)));
      end
      if (x[31] == y[31]) begin
         sum = mx + my;
         s   = x[31];
      end else if (mx >= my) begin
         sum = mx - my;
         s   = x[31];
      end else begin
         sum = my - mx;
         s   = y[31];
      end
      if (sum == 0) begin
         return 32'b0;
      end
      return round_single(s, sum, xe - lead - 150);
   endfunction

   function automatic logic [31:0] single_sub(logic [31:0] a, logic [31:0] b);
      return single_add(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] canonical(logic [31:0] a);
      return is_nan(a) ? QNAN_BITS : a;
   endfunction

   function automatic normal_beat_type triangle_normal(logic [287:0] v);
      logic [31:0]  w [9];
      logic [31:0]  ex, ey, ez, fx, fy, fz, nx, ny, nz, len2, seed, half_len, r;
      normal_beat_type o;
      for (int i = 0; i < 9; i++) begin
         w[i] = v[32*i +: 32];
      end
      ex = single_sub(w[3], w[0]);
      ey = single_sub(w[4], w[1]);
      ez = single_sub(w[5], w[2]);
      fx = single_sub(w[6], w[0]);
      fy = single_sub(w[7], w[1]);
      fz = single_sub(w[8], w[2]);
      nx = single_sub(single_mul(ey, fz), single_mul(ez, fy));
      ny = single_sub(single_mul(ez, fx), single_mul(ex, fz));
      nz = single_sub(single_mul(ex, fy), single_mul(ey, fx));
      len2 = single_add(single_add(single_mul(nx, nx), single_mul(ny, ny)),
                        single_mul(nz, nz));
      seed     = RSQRT_SEED - (len2 >> 1);
      half_len = single_mul(single_mul(single_mul(len2, HALF_BITS), seed), seed);
      r        = single_mul(seed, single_sub(THREE_HALF, half_len));
      o.nx = canonical(nx);
      o.ny = canonical(ny);
      o.nz = canonical(nz);
      o.ux = canonical(single_mul(nx, r));
      o.uy = canonical(single_mul(ny, r));
      o.uz = canonical(single_mul(nz, r));
      return o;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(8, 30);
      end
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic logic [31:0] special_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7F80_0000;
         3: return 32'hFF80_0000;
         4: return 32'h7FC0_0001 | ($urandom() & 32'h803F_FFFF);
         5: return 32'h7F7F_FFFF;
         6: return 32'h0000_0001;
         7: return $urandom() & 32'h807F_FFFF;
         8: return {$urandom_range(0, 1) == 1, 8'd254, 23'($urandom())};
         default: return {$urandom_range(0, 1) == 1, 8'd1, 23'($urandom())};
      endcase
   endfunction

   function automatic logic [31:0] coord_word();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return $urandom();
      end
      if (pick == 1) begin
         return special_word();
      end
      if (pick == 2) begin
         return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 254)), 23'($urandom())};
      end
      return {$urandom_range(0, 1) == 1, 8'($urandom_range(117, 137)), 23'($urandom())};
   endfunction

   // The valid stays high after a beat and drops only when a gap follows.
   task automatic send_triangle(logic [287:0] verts);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= verts;
      do begin
         @(posedge clock);
      end while (!req_tready);
      normals_due.push_back(triangle_normal(verts));
   endtask

   task automatic send_words(logic [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
      send_triangle({c2, c1, c0, b2, b1, b0, a2, a1, a0});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_words(0, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0);
      send_words(0, 0, 0, 32'h3F80_0000, 0, 0, 32'h4000_0000, 0, 0);
      send_words(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_words(32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000, 0, 0, 0, 0);
      send_words(0, 0, 0, 32'h7F80_0000, 0, 0, 0, 32'h3F80_0000, 0);
      send_words(0, 0, 0, 32'h7F80_0000, 0, 0, 0, 32'h7F80_0000, 0);
      send_words(32'h7F80_0000, 0, 0, 32'h7F80_0000, 0, 0, 0, 32'h3F80_0000, 0);
      send_words(32'h7FC0_0000, 0, 0, 32'h3F80_0000, 0, 0, 0, 32'h3F80_0000, 0);
      send_words(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h3F80_0000, 0);
      send_words(0, 0, 0, 32'h7F7F_FFFF, 0, 0, 0, 32'h7F7F_FFFF, 0);
      send_words(32'hFF7F_FFFF, 0, 0, 32'h7F7F_FFFF, 0, 0, 0, 32'h4000_0000, 0);
      send_words(0, 0, 0, 32'h0000_0001, 0, 0, 0, 32'h0000_0001, 0);
      send_words(0, 0, 0, 32'h0080_0000, 0, 0, 0, 32'h0040_0000, 32'h0000_0003);
      send_words(0, 0, 0, 32'h1F80_0000, 0, 0, 0, 32'h1F80_0000, 0);
      send_words(32'h3F80_0000, 32'h3F80_0001, 0, 32'h3F80_0001, 32'h3F80_0000, 0,
                 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
      send_words(32'h4040_0000, 32'hC0A0_0000, 32'h3E80_0000, 32'hBF00_0000, 32'h4120_0000,
                 32'h42C8_0000, 32'h4700_0000, 32'hC2F6_0000, 32'h3DCC_CCCD);
      send_words(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_words(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_words(0, 0, 0, 32'h5F00_0000, 0, 0, 0, 32'h5F00_0000, 0);
      send_words(0, 0, 0, 32'h2000_0000, 32'h2000_0000, 0, 0, 0, 32'h2000_0000);
   endtask

   task automatic test_random(int count);
      logic [31:0] w [9];
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) begin
            w[i] = coord_word();
            if (i >= 3 && $urandom_range(0, 9) == 0) begin
               w[i] = w[i % 3];
            end else if (i >= 3 && $urandom_range(0, 9) == 0) begin
               w[i] = w[i % 3] ^ 32'($urandom_range(0, 3));
            end
         end
         send_words(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
      end
   endtask

   task automatic test_back_to_back(int count);
      stall_free = 1'b1;
      for (int n = 0; n < count; n++) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {9{coord_word()}} ^ {$urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom(), $urandom()}
                        & {9{32'h807F_FFFF}};
         do begin
            @(posedge clock);
         end while (!req_tready);
         normals_due.push_back(triangle_normal(req_tdata));
      end
      wait_drained();
      stall_free = 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_free) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
         rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         rsp_tready <= ($urandom_range(0, 5) == 0);
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      normal_beat_type want;
      logic [31:0]  got [6];
      logic [31:0]  exp_w [6];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (normals_due.size() == 0) begin
            $display("%0t unexpected beat %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = normals_due.pop_front();
            exp_w = '{want.nx, want.ny, want.nz, want.ux, want.uy, want.uz};
            for (int i = 0; i < 6; i++) begin
               got[i] = rsp_tdata[32*i +: 32];
               if (got[i] !== exp_w[i]) begin
                  $display("%0t field %0d expected %h actual %h", $time, i, exp_w[i],
                           got[i]);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400);
      wait_drained();
      test_back_to_back(60);
      test_random(440);
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && normals_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
